// File: src/rhcc_pkg.sv
// Shared constants and helpers for the RGB/HSV color converter.
package rhcc_pkg;

    localparam int FRAC_BITS = 15;
    localparam int CW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 1;
    localparam int PW = 16;
    localparam int EW = (CW > PW) ? CW : PW;

    localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic FUNC_RGB2HSV = 1'b0;
    localparam logic FUNC_HSV2RGB = 1'b1;

    function automatic logic [CW-1:0] clamp_in(input logic [PW-1:0] x);
        logic [EW-1:0] ext;
        ext = EW'(x);
        return (ext > EW'(ONE)) ? ONE : ext[CW-1:0];
    endfunction

    function automatic logic [PW-1:0] to_out(input logic [CW-1:0] x);
        logic [CW+PW-1:0] ext;
        ext = (CW+PW)'(x);
        return ext[PW-1:0];
    endfunction

endpackage

// File: src/rhcc_div.sv
// Pipelined restoring divider, one quotient bit per stage: q = (num << FRAC_BITS) / den.
module rhcc_div (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [rhcc_pkg::DW-1:0] num_in,
    input  logic [rhcc_pkg::DW-1:0] den_in,
    output logic [rhcc_pkg::QW-1:0] q_out
);
    import rhcc_pkg::*;

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] low_next [QW];
    logic [DW-1:0] den_next [QW];
    logic [QW-1:0] q_next   [QW];

    always_comb begin
        logic [DW-1:0] prem;
        logic [QW-1:0] plow;
        logic [DW-1:0] pden;
        logic [QW-1:0] pq;
        logic [DW:0]   t;
        logic          ge;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                prem = num_in >> 1;
                plow = {num_in[0], {FRAC_BITS{1'b0}}};
                pden = den_in;
                pq   = '0;
            end else begin
                prem = rem_reg[k-1];
                plow = low_reg[k-1];
                pden = den_reg[k-1];
                pq   = q_reg[k-1];
            end
            t  = {prem, plow[QW-1]};
            ge = (t >= {1'b0, pden});
            rem_next[k] = ge ? DW'(t - {1'b0, pden}) : t[DW-1:0];
            low_next[k] = plow << 1;
            den_next[k] = pden;
            q_next[k]   = {pq[QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                den_reg[k] <= den_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign q_out = q_reg[QW-1];

endmodule

// File: src/rhcc_hsv2rgb.sv
// HSV to RGB datapath: two multiply stages, sextant select, then delay to divider latency.
module rhcc_hsv2rgb (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [2:0]                    i_in,
    input  logic [rhcc_pkg::FRAC_BITS-1:0] f_in,
    input  logic [rhcc_pkg::CW-1:0]        s_in,
    input  logic [rhcc_pkg::CW-1:0]        v_in,
    input  logic                          sz_in,
    output logic [rhcc_pkg::CW-1:0]        r_out,
    output logic [rhcc_pkg::CW-1:0]        g_out,
    output logic [rhcc_pkg::CW-1:0]        b_out
);
    import rhcc_pkg::*;

    localparam int DLY = QW - 3;

    logic [CW-1:0]   p3_reg, sf3_reg, s1f3_reg, v3_reg;
    logic [2:0]      i3_reg, i4_reg;
    logic            sz3_reg, sz4_reg;
    logic [CW-1:0]   p4_reg, q4_reg, t4_reg, v4_reg;
    logic [CW-1:0]   a5_reg, b5_reg, c5_reg;
    logic [CW-1:0]   da_reg [DLY];
    logic [CW-1:0]   db_reg [DLY];
    logic [CW-1:0]   dc_reg [DLY];

    logic [2*CW-1:0] p_prod, sf_prod, s1f_prod, q_prod, t_prod;
    logic [CW-1:0]   f_ext;
    logic [CW-1:0]   a5_next, b5_next, c5_next;

    assign f_ext    = CW'(f_in);
    assign p_prod   = v_in * (ONE - s_in);
    assign sf_prod  = s_in * f_ext;
    assign s1f_prod = s_in * (ONE - f_ext);
    assign q_prod   = v3_reg * (ONE - sf3_reg);
    assign t_prod   = v3_reg * (ONE - s1f3_reg);

    always_comb begin
        if (sz4_reg) begin
            a5_next = v4_reg; b5_next = v4_reg; c5_next = v4_reg;
        end else begin
            case (i4_reg)
                3'd0: begin a5_next = v4_reg; b5_next = t4_reg; c5_next = p4_reg; end
                3'd1: begin a5_next = q4_reg; b5_next = v4_reg; c5_next = p4_reg; end
                3'd2: begin a5_next = p4_reg; b5_next = v4_reg; c5_next = t4_reg; end
                3'd3: begin a5_next = p4_reg; b5_next = q4_reg; c5_next = v4_reg; end
                3'd4: begin a5_next = t4_reg; b5_next = p4_reg; c5_next = v4_reg; end
                default: begin a5_next = v4_reg; b5_next = p4_reg; c5_next = q4_reg; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg   <= p_prod[FRAC_BITS +: CW];
            sf3_reg  <= sf_prod[FRAC_BITS +: CW];
            s1f3_reg <= s1f_prod[FRAC_BITS +: CW];
            v3_reg   <= v_in;
            i3_reg   <= i_in;
            sz3_reg  <= sz_in;
            p4_reg   <= p3_reg;
            q4_reg   <= q_prod[FRAC_BITS +: CW];
            t4_reg   <= t_prod[FRAC_BITS +: CW];
            v4_reg   <= v3_reg;
            i4_reg   <= i3_reg;
            sz4_reg  <= sz3_reg;
            a5_reg   <= a5_next;
            b5_reg   <= b5_next;
            c5_reg   <= c5_next;
            for (int k = 0; k < DLY; k++) begin
                da_reg[k] <= (k == 0) ? a5_reg : da_reg[k-1];
                db_reg[k] <= (k == 0) ? b5_reg : db_reg[k-1];
                dc_reg[k] <= (k == 0) ? c5_reg : dc_reg[k-1];
            end
        end
    end

    assign r_out = da_reg[DLY-1];
    assign g_out = db_reg[DLY-1];
    assign b_out = dc_reg[DLY-1];

endmodule

// File: src/rgb_hsv_color_converter.sv
// Top level of the RGB/HSV color converter pipeline.
// Converts one color per beat, RGB to HSV or HSV to RGB as s_tuser selects, with
// channels in fixed point where 32768 means 1.0 and larger inputs clamp to 1.0. A new
// beat is taken every cycle unless the pipeline holds; a result passes the input register,
// the stage-2 registers, the two bit-per-stage hue and saturation dividers and the output
// register. The whole pipeline holds when m_tready is low and the output register is full.
module rgb_hsv_color_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // chan_a [15:0], chan_b [31:16], chan_c [47:32]
    input  logic [0:0]  s_tuser,   // func [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // out_a [15:0], out_b [31:16], out_c [47:32]
);
    import rhcc_pkg::*;

    logic          en;
    logic          v1_reg, v2_reg, m_tvalid_reg;
    logic          func1_reg, func2_reg;
    logic [CW-1:0] a1_reg, b1_reg, c1_reg;
    logic [DW-1:0] snum2_reg, sden2_reg, hnum2_reg, hden2_reg;
    logic [CW-1:0] mx2_reg;
    logic          blk2_reg, grey2_reg;
    logic [2:0]    i2_reg;
    logic [FRAC_BITS-1:0] f2_reg;
    logic [CW-1:0] s2_reg, vv2_reg;
    logic          sz2_reg;
    logic          dv_reg    [QW];
    logic          dfunc_reg [QW];
    logic          dblk_reg  [QW];
    logic          dgrey_reg [QW];
    logic [CW-1:0] dmx_reg   [QW];
    logic [47:0]   m_tdata_reg;

    logic [CW-1:0] mx, mn, delta, h_w;
    logic [DW-1:0] d_ext, two_d, four_d, six_d, hnum, hx, h6;
    logic [DW-1:0] r_x, g_x, b_x;
    logic [QW-1:0] sat_q, hue_q;
    logic [CW-1:0] rr, gg, bb, fa, fb;
    logic [47:0]   m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        mx = a1_reg;
        if (b1_reg > mx) mx = b1_reg;
        if (c1_reg > mx) mx = c1_reg;
        mn = a1_reg;
        if (b1_reg < mn) mn = b1_reg;
        if (c1_reg < mn) mn = c1_reg;
        delta  = mx - mn;
        d_ext  = DW'(delta);
        two_d  = d_ext << 1;
        four_d = d_ext << 2;
        six_d  = four_d + two_d;
        r_x    = DW'(a1_reg);
        g_x    = DW'(b1_reg);
        b_x    = DW'(c1_reg);
        if (a1_reg == mx) begin
            hnum = (g_x >= b_x) ? g_x - b_x : six_d - (b_x - g_x);
        end else if (b1_reg == mx) begin
            hnum = (b_x >= r_x) ? two_d + (b_x - r_x) : two_d - (r_x - b_x);
        end else begin
            hnum = (r_x >= g_x) ? four_d + (r_x - g_x) : four_d - (g_x - r_x);
        end
        h_w = (a1_reg == ONE) ? '0 : a1_reg;
        hx  = DW'(h_w);
        h6  = (hx << 2) + (hx << 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg <= s_tuser[0];
            a1_reg    <= clamp_in(s_tdata[15:0]);
            b1_reg    <= clamp_in(s_tdata[31:16]);
            c1_reg    <= clamp_in(s_tdata[47:32]);
            func2_reg <= func1_reg;
            snum2_reg <= d_ext;
            sden2_reg <= DW'(mx);
            hnum2_reg <= hnum;
            hden2_reg <= six_d;
            mx2_reg   <= mx;
            blk2_reg  <= (mx == '0);
            grey2_reg <= (delta == '0);
            i2_reg    <= h6[DW-1:FRAC_BITS];
            f2_reg    <= h6[FRAC_BITS-1:0];
            s2_reg    <= b1_reg;
            vv2_reg   <= c1_reg;
            sz2_reg   <= (b1_reg == '0);
            for (int k = 0; k < QW; k++) begin
                dfunc_reg[k] <= (k == 0) ? func2_reg : dfunc_reg[k-1];
                dblk_reg[k]  <= (k == 0) ? blk2_reg  : dblk_reg[k-1];
                dgrey_reg[k] <= (k == 0) ? grey2_reg : dgrey_reg[k-1];
                dmx_reg[k]   <= (k == 0) ? mx2_reg   : dmx_reg[k-1];
            end
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < QW; k++) dv_reg[k] <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            for (int k = 0; k < QW; k++) dv_reg[k] <= (k == 0) ? v2_reg : dv_reg[k-1];
            m_tvalid_reg <= dv_reg[QW-1];
        end
    end

    rhcc_div u_sat_div (
        .aclk   (aclk),
        .en     (en),
        .num_in (snum2_reg),
        .den_in (sden2_reg),
        .q_out  (sat_q)
    );

    rhcc_div u_hue_div (
        .aclk   (aclk),
        .en     (en),
        .num_in (hnum2_reg),
        .den_in (hden2_reg),
        .q_out  (hue_q)
    );

    rhcc_hsv2rgb u_hsv2rgb (
        .aclk  (aclk),
        .en    (en),
        .i_in  (i2_reg),
        .f_in  (f2_reg),
        .s_in  (s2_reg),
        .v_in  (vv2_reg),
        .sz_in (sz2_reg),
        .r_out (rr),
        .g_out (gg),
        .b_out (bb)
    );

    always_comb begin
        fa = (dblk_reg[QW-1] || dgrey_reg[QW-1]) ? '0 : CW'(hue_q);
        fb = dblk_reg[QW-1] ? '0 : CW'(sat_q);
        if (dfunc_reg[QW-1] == FUNC_HSV2RGB) begin
            m_tdata_next = {to_out(bb), to_out(gg), to_out(rr)};
        end else begin
            m_tdata_next = {to_out(dmx_reg[QW-1]), to_out(fb), to_out(fa)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the RGB/HSV color converter stream block.
`timescale 1ns / 100ps

module tb;
    import rhcc_pkg::*;

    typedef struct packed {
        logic        func;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
    } color_in_t;

    typedef struct packed {
        logic [15:0] oa;
        logic [15:0] ob;
        logic [15:0] oc;
    } color_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    color_in_t  pending_colors[$];
    color_out_t expected_colors[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         stim_done = 1'b0;

    rgb_hsv_color_converter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned clamp_chan(input logic [15:0] x);
        longint unsigned one;
        one = longint'(1) << FRAC_BITS;
        return (x > one) ? one : longint'(x);
    endfunction

    function automatic color_out_t convert_color(input color_in_t c);
        longint unsigned a, b, d, one, mx, mn, dl, num, h6, i, f, p, q, t;
        longint unsigned x, y, z;
        color_out_t r;
        one = longint'(1) << FRAC_BITS;
        a = clamp_chan(c.ca);
        b = clamp_chan(c.cb);
        d = clamp_chan(c.cc);
        if (c.func == FUNC_RGB2HSV) begin
            mx = a; mn = a;
            if (b > mx) mx = b;
            if (d > mx) mx = d;
            if (b < mn) mn = b;
            if (d < mn) mn = d;
            z = mx; x = 0; y = 0;
            if (mx != 0) begin
                dl = mx - mn;
                y = (dl << FRAC_BITS) / mx;
                if (dl != 0) begin
                    if (a == mx)
                        num = (b >= d) ? b - d : 6 * dl - (d - b);
                    else if (b == mx)
                        num = (d >= a) ? 2 * dl + (d - a) : 2 * dl - (a - d);
                    else
                        num = (a >= b) ? 4 * dl + (a - b) : 4 * dl - (b - a);
                    x = (num << FRAC_BITS) / (6 * dl);
                end
            end
        end else if (b == 0) begin
            x = d; y = d; z = d;
        end else begin
            if (a == one) a = 0;
            h6 = a * 6;
            i = h6 >> FRAC_BITS;
            f = h6 & (one - 1);
            p = (d * (one - b)) >> FRAC_BITS;
            q = (d * (one - ((b * f) >> FRAC_BITS))) >> FRAC_BITS;
            t = (d * (one - ((b * (one - f)) >> FRAC_BITS))) >> FRAC_BITS;
            case (i)
                0: begin x = d; y = t; z = p; end
                1: begin x = q; y = d; z = p; end
                2: begin x = p; y = d; z = t; end
                3: begin x = p; y = q; z = d; end
                4: begin x = t; y = p; z = d; end
                default: begin x = d; y = p; z = q; end
            endcase
        end
        r.oa = x[15:0];
        r.ob = y[15:0];
        r.oc = z[15:0];
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        color_in_t nxt;
        if (aresetn && !(s_tvalid && !s_tready)) begin
            if (s_tvalid) expected_colors.push_back(convert_color({s_tuser[0], s_tdata[15:0],
                s_tdata[31:16], s_tdata[47:32]}));
            if (pending_colors.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_colors.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.func;
                s_tdata  <= {nxt.cc, nxt.cb, nxt.ca};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        color_out_t exp_c, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
                end else begin
                    exp_c = expected_colors.pop_front();
                    if (got !== exp_c) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp a=%0d b=%0d c=%0d got a=%0d b=%0d c=%0d",
                                exp_c.oa, exp_c.ob, exp_c.oc, got.oa, got.ob, got.oc);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(9))
            0: return 16'($urandom_range(32769, 65535));
            1: return 16'(1 << FRAC_BITS);
            2: return 16'h0;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic add_color(input logic fn, input logic [15:0] a, b, c);
        color_in_t ci;
        ci.func = fn; ci.ca = a; ci.cb = b; ci.cc = c;
        pending_colors.push_back(ci);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n);
        logic [15:0] g;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            if ($urandom_range(7) == 0) begin
                g = rand_chan();
                add_color(1'($urandom_range(1)), g, g, g);
            end else begin
                add_color(1'($urandom_range(1)), rand_chan(), rand_chan(), rand_chan());
            end
        end
        while (pending_colors.size() > 0 || s_tvalid) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // black, grey, over-range, each max channel and tie order
        add_color(FUNC_RGB2HSV, 16'h0, 16'h0, 16'h0);
        add_color(FUNC_RGB2HSV, 16'd1000, 16'd1000, 16'd1000);
        add_color(FUNC_RGB2HSV, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_color(FUNC_RGB2HSV, 16'h8000, 16'h0, 16'h0);
        add_color(FUNC_RGB2HSV, 16'h0, 16'h8000, 16'h0);
        add_color(FUNC_RGB2HSV, 16'h0, 16'h0, 16'h8000);
        add_color(FUNC_RGB2HSV, 16'h8000, 16'h0, 16'h4000);
        add_color(FUNC_RGB2HSV, 16'h8000, 16'h8000, 16'h0);
        add_color(FUNC_RGB2HSV, 16'h0, 16'hFFFF, 16'hFFFF);
        add_color(FUNC_RGB2HSV, 16'h1234, 16'h5678, 16'h0001);
        add_color(FUNC_RGB2HSV, 16'h7FFF, 16'h0001, 16'h3333);
        // zero saturation, full-turn hue, each sextant, clamping
        add_color(FUNC_HSV2RGB, 16'h4000, 16'h0, 16'h6000);
        add_color(FUNC_HSV2RGB, 16'h8000, 16'h8000, 16'h8000);
        add_color(FUNC_HSV2RGB, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 6; k++)
            add_color(FUNC_HSV2RGB, 16'(k * 5461 + 100), 16'h6000, 16'h7000);
        add_color(FUNC_HSV2RGB, 16'h7FFF, 16'h0001, 16'h8000);
        add_color(FUNC_HSV2RGB, 16'h0, 16'h8000, 16'h0);
        run_phase(0, 0, 300);
        run_phase(69, 0, 250);
        run_phase(0, 69, 250);
        run_phase(26, 26, 200);
        recv_stall_pct = 0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (expected_colors.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
